/* rtl/core/ohlc_pkg.sv */
// shared types, constants and helpers for the ohlc bar aggregator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package ohlc_pkg;

  localparam int SLOTS    = 256;
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int TIME_W   = 63;
  localparam int PRICE_W  = 48;
  localparam int VOL_W    = 48;
  localparam int CNT_W    = 32;
  localparam int IV_W     = 46;

  localparam logic [IV_W-1:0]   IV_RESET = 46'd60000000000;
  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  localparam logic CMD_SUBSCRIBE = 1'b0;
  localparam logic CMD_TRADE     = 1'b1;

  typedef struct packed {
    logic [TIME_W-1:0]         win_start;
    logic [TIME_W-1:0]         win_end;
    logic signed [PRICE_W-1:0] open_p;
    logic signed [PRICE_W-1:0] high_p;
    logic signed [PRICE_W-1:0] low_p;
    logic signed [PRICE_W-1:0] close_p;
    logic [VOL_W-1:0]          first_vol;
    logic [VOL_W-1:0]          win_vol;
    logic [CNT_W-1:0]          count;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_ALIGN,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] dividend;
    logic [IV_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [IV_W-1:0] rem;
  } div_rsp_t;

  function automatic logic [TIME_W-1:0] add_sat63(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/core/ohlc_mod_unit.sv */
// bit-serial restoring remainder unit, one dividend bit per cycle
// depends on ohlc_pkg
`timescale 1ns / 1ps
`default_nettype none
module ohlc_mod_unit (
  input  wire              clk,
  input  wire              rst,
  input  ohlc_pkg::div_req_t req,
  output ohlc_pkg::div_rsp_t rsp
);
  import ohlc_pkg::*;

  localparam int STEP_W = $clog2(TIME_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(TIME_W - 1);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [TIME_W-1:0] shift;
  logic [IV_W-1:0]   divisor;
  logic [IV_W-1:0]   rem;
  logic [IV_W:0]     trial;

  assign trial = {rem, shift[TIME_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && step == LAST_STEP) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      step    <= '0;
      shift   <= req.dividend;
      divisor <= req.divisor;
      rem     <= '0;
    end else if (busy) begin
      step  <= step + STEP_W'(1);
      shift <= {shift[TIME_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem <= IV_W'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[IV_W-1:0];
      end
    end
  end

  assign rsp = {done, rem};

endmodule
`default_nettype wire

/* rtl/core/ohlc_bar_mem.sv */
// per-slot bar table, one write port and one registered read port
// depends on ohlc_pkg
`timescale 1ns / 1ps
`default_nettype none
module ohlc_bar_mem (
  input  wire                          clk,
  input  wire                          rd_en,
  input  wire [ohlc_pkg::SLOT_W-1:0]   rd_addr,
  output ohlc_pkg::entry_t             rd_data,
  input  wire                          wr_en,
  input  wire [ohlc_pkg::SLOT_W-1:0]   wr_addr,
  input  ohlc_pkg::entry_t             wr_data
);
  import ohlc_pkg::*;

  entry_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* rtl/core/ohlc_bar_aggregator.sv */
// ohlc bar aggregator top level: per-slot time bars kept in one table memory
// flow: a trade folded into its bar goes through read and finish; a subscribe or a
//   trade past its end also goes through divide (63-step remainder unit) and align
// throughput: one request at a time, which may also wait on a stalled
//   bar; a finished bar waits in the output register while the next request is taken
// reset: synchronous, clears slot valid bits, fsm and output valid; interval to 60 s
`timescale 1ns / 1ps
`default_nettype none
module ohlc_bar_aggregator (
  input  wire                                clk,
  input  wire                                rst,
  // configuration
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire [ohlc_pkg::IV_W-1:0]           interval_ns,
  // input requests
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire                                cmd,
  input  wire [ohlc_pkg::SLOT_W-1:0]         slot,
  input  wire [ohlc_pkg::TIME_W-1:0]         time_ns,
  input  wire signed [ohlc_pkg::PRICE_W-1:0] price,
  input  wire [ohlc_pkg::VOL_W-1:0]          cum_volume,
  // finished bars
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic [ohlc_pkg::SLOT_W-1:0]        bar_slot,
  output logic [ohlc_pkg::TIME_W-1:0]        bar_start,
  output logic [ohlc_pkg::TIME_W-1:0]        bar_end,
  output logic signed [ohlc_pkg::PRICE_W-1:0] open_price,
  output logic signed [ohlc_pkg::PRICE_W-1:0] high_price,
  output logic signed [ohlc_pkg::PRICE_W-1:0] low_price,
  output logic signed [ohlc_pkg::PRICE_W-1:0] close_price,
  output logic [ohlc_pkg::VOL_W-1:0]         bar_volume,
  output logic [ohlc_pkg::CNT_W-1:0]         tick_count
);
  import ohlc_pkg::*;

  // interval register, zero behaves as one
  logic [IV_W-1:0] interval;
  logic [IV_W-1:0] iv;
  assign cfg_ready = 1'b1;
  assign iv = (interval == '0) ? IV_W'(1) : interval;

  always_ff @(posedge clk) begin
    if (rst) begin
      interval <= IV_RESET;
    end else if (cfg_valid && cfg_ready) begin
      interval <= interval_ns;
    end
  end

  // captured request
  logic                      cmd_q;
  logic [SLOT_W-1:0]         slot_q;
  logic [TIME_W-1:0]         t_q;
  logic signed [PRICE_W-1:0] p_q;
  logic [VOL_W-1:0]          vol_q;

  logic in_accept;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_q  <= cmd;
      slot_q <= slot;
      t_q    <= time_ns;
      p_q    <= price;
      vol_q  <= cum_volume;
    end
  end

  // slot armed bits live in flops so reset clears them at once
  logic [SLOTS-1:0] slot_valid;
  logic             vld;
  assign vld = slot_valid[slot_q];

  // table memory
  entry_t ent;
  entry_t wr_ent;
  logic   mem_we;

  ohlc_bar_mem u_mem (
    .clk     (clk),
    .rd_en   (in_accept),
    .rd_addr (slot),
    .rd_data (ent),
    .wr_en   (mem_we),
    .wr_addr (slot_q),
    .wr_data (wr_ent)
  );

  // remainder unit for window alignment
  div_req_t div_req;
  div_rsp_t div_rsp;

  ohlc_mod_unit u_mod (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // decisions made once the entry is read
  logic is_sub;
  logic in_win;
  logic at_end;
  logic past_end;
  assign is_sub   = (cmd_q == CMD_SUBSCRIBE);
  assign in_win   = (t_q >= ent.win_start) && (t_q <= ent.win_end);
  assign past_end = (t_q >= ent.win_end);
  assign at_end   = (t_q == ent.win_end);

  logic rd_drop;     // request has no effect
  logic rd_to_div;   // alignment needs a remainder
  assign rd_drop   = is_sub ? vld : (!vld || (!in_win && !past_end));
  assign rd_to_div = is_sub || (past_end && !at_end);

  state_t state, state_next;
  logic   fold_q, emit_q;
  logic [TIME_W-1:0] st_q;
  logic   out_free;
  logic   fin_go;

  assign out_free = !out_valid || !out_stall;
  assign fin_go   = !emit_q || out_free;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid) state_next = ST_READ;
      ST_READ: begin
        if (rd_drop) begin
          state_next = ST_IDLE;
        end else if (rd_to_div) begin
          state_next = ST_DIV;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_DIV:   if (div_rsp.done) state_next = ST_ALIGN;
      ST_ALIGN: state_next = ST_FIN;
      ST_FIN:   if (fin_go) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // control outputs
  logic out_load;
  always_comb begin
    in_stall         = 1'b1;
    div_req.start    = 1'b0;
    // dividend: time for subscribe, distance past end minus one for a jump
    div_req.dividend = is_sub ? t_q : (t_q - ent.win_end - TIME_W'(1));
    div_req.divisor  = iv;
    mem_we           = 1'b0;
    out_load         = 1'b0;
    case (state)
      ST_IDLE: in_stall = 1'b0;
      ST_READ: div_req.start = !rd_drop && rd_to_div;
      ST_FIN: begin
        mem_we   = fin_go;
        out_load = fin_go && emit_q;
      end
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // flags and aligned start
  logic [TIME_W:0] sub_sum;
  assign sub_sum = {1'b0, t_q - TIME_W'(div_rsp.rem)} + (TIME_W+1)'(iv);

  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      fold_q <= !is_sub && in_win;
      emit_q <= !is_sub && past_end;
      st_q   <= t_q;  // trade exactly at the end starts the next bar there
    end else if (state == ST_ALIGN) begin
      if (is_sub) begin
        st_q <= sub_sum[TIME_W] ? TIME_MAX : sub_sum[TIME_W-1:0];
      end else begin
        st_q <= t_q - TIME_W'(1) - TIME_W'(div_rsp.rem);
      end
    end
  end

  // bar with this trade folded in
  entry_t folded;
  entry_t bar;
  always_comb begin
    folded = ent;
    if (ent.count == '0) begin
      folded.count     = CNT_W'(1);
      folded.first_vol = vol_q;
      folded.open_p    = p_q;
      folded.high_p    = p_q;
      folded.low_p     = p_q;
      folded.close_p   = p_q;
    end else begin
      if (ent.count != CNT_MAX) folded.count = ent.count + CNT_W'(1);
      if (p_q > ent.high_p) folded.high_p = p_q;
      if (p_q < ent.low_p)  folded.low_p  = p_q;
      folded.close_p = p_q;
    end
    folded.win_vol = (vol_q >= folded.first_vol) ? (vol_q - folded.first_vol) : '0;
    bar = fold_q ? folded : ent;
  end

  // entry written back
  always_comb begin
    if (is_sub) begin
      wr_ent           = '0;
      wr_ent.win_start = st_q;
      wr_ent.win_end   = add_sat63(st_q, TIME_W'(iv));
    end else if (emit_q) begin
      wr_ent           = '0;
      wr_ent.win_start = st_q;
      wr_ent.win_end   = add_sat63(st_q, TIME_W'(iv));
      wr_ent.count     = CNT_W'(1);
      wr_ent.first_vol = vol_q;
      wr_ent.open_p    = p_q;
      wr_ent.high_p    = p_q;
      wr_ent.low_p     = p_q;
      wr_ent.close_p   = p_q;
    end else begin
      wr_ent = folded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (mem_we && is_sub) begin
      slot_valid[slot_q] <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      bar_slot    <= slot_q;
      bar_start   <= bar.win_start;
      bar_end     <= bar.win_end;
      open_price  <= bar.open_p;
      high_price  <= bar.high_p;
      low_price   <= bar.low_p;
      close_price <= bar.close_p;
      bar_volume  <= bar.win_vol;
      tick_count  <= bar.count;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/ohlc_checker.sv */
// port-level checks for the ohlc bar aggregator, bound to the top level
// depends on ohlc_pkg and ohlc_bar_aggregator
`timescale 1ns / 1ps
`default_nettype none
module ohlc_checker (
  input wire                           clk,
  input wire                           rst,
  input wire                           in_valid,
  input wire                           in_stall,
  input wire                           cmd,
  input wire                           out_valid,
  input wire                           out_stall,
  input wire [ohlc_pkg::TIME_W-1:0]    bar_start,
  input wire [ohlc_pkg::CNT_W-1:0]     tick_count
);
  import ohlc_pkg::*;

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while busy");

  // a subscribe request never produces a bar
  a_sub_no_bar: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && cmd == CMD_SUBSCRIBE) |=> !$rose(out_valid))
    else $error("bar after subscribe");

  // a waiting bar stays and holds its fields
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(bar_start) && $stable(tick_count)))
    else $error("stalled bar changed");

  // reset leaves no bar and an idle input
  a_reset_clean: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("state after reset");

endmodule

bind ohlc_bar_aggregator ohlc_checker u_ohlc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .cmd        (cmd),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .bar_start  (bar_start),
  .tick_count (tick_count)
);
`default_nettype wire

/* sim/ohlc_bar_checker.sv */
// checker for the ohlc bar aggregator: tracks per-slot bar state from the
// accepted requests and compares finished bars in order; depends on ohlc_pkg
`timescale 1ns / 1ps
module ohlc_bar_checker (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cfg_valid,
  input  wire                                cfg_ready,
  input  wire [ohlc_pkg::IV_W-1:0]           interval_ns,
  input  wire                                in_valid,
  input  wire                                in_stall,
  input  wire                                cmd,
  input  wire [ohlc_pkg::SLOT_W-1:0]         slot,
  input  wire [ohlc_pkg::TIME_W-1:0]         time_ns,
  input  wire signed [ohlc_pkg::PRICE_W-1:0] price,
  input  wire [ohlc_pkg::VOL_W-1:0]          cum_volume,
  input  wire                                out_valid,
  input  wire                                out_stall,
  input  wire [ohlc_pkg::SLOT_W-1:0]         bar_slot,
  input  wire [ohlc_pkg::TIME_W-1:0]         bar_start,
  input  wire [ohlc_pkg::TIME_W-1:0]         bar_end,
  input  wire signed [ohlc_pkg::PRICE_W-1:0] open_price,
  input  wire signed [ohlc_pkg::PRICE_W-1:0] high_price,
  input  wire signed [ohlc_pkg::PRICE_W-1:0] low_price,
  input  wire signed [ohlc_pkg::PRICE_W-1:0] close_price,
  input  wire [ohlc_pkg::VOL_W-1:0]          bar_volume,
  input  wire [ohlc_pkg::CNT_W-1:0]          tick_count,
  output int                                 fail_count,
  output int                                 bars_pending
);
  import ohlc_pkg::*;

  typedef struct packed {
    logic [SLOT_W-1:0]         bslot;
    logic [TIME_W-1:0]         bstart;
    logic [TIME_W-1:0]         bend;
    logic signed [PRICE_W-1:0] op;
    logic signed [PRICE_W-1:0] hp;
    logic signed [PRICE_W-1:0] lp;
    logic signed [PRICE_W-1:0] cp;
    logic [VOL_W-1:0]          vol;
    logic [CNT_W-1:0]          cnt;
  } bar_t;

  bar_t         bar_queue[$];
  logic [IV_W-1:0] bar_len;
  logic         armed [SLOTS];
  entry_t       book [SLOTS];

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return (s > {1'b0, TIME_MAX}) ? {1'b0, TIME_MAX} : s;
  endfunction

  // fold one accepted request into the slot table, queue a bar if one closes
  task automatic fold_request(input logic c, input int s, input logic [63:0] t,
                              input logic signed [PRICE_W-1:0] p,
                              input logic [VOL_W-1:0] v);
    logic [63:0] iv, st, d, k;
    entry_t e;
    bar_t b;
    iv = (bar_len == 0) ? 64'd1 : {18'd0, bar_len};
    e = book[s];
    if (c == CMD_SUBSCRIBE) begin
      if (armed[s]) return;
      st = sat_add(t - t % iv, iv);
      armed[s] = 1'b1;
      e = '0;
      e.win_start = st[TIME_W-1:0];
      d = sat_add(st, iv);
      e.win_end = d[TIME_W-1:0];
      book[s] = e;
      return;
    end
    if (!armed[s]) return;
    if (t >= e.win_start && t <= e.win_end) begin
      if (e.count == 0) begin
        e.count = 1; e.first_vol = v; e.open_p = p; e.high_p = p; e.low_p = p; e.close_p = p;
      end else begin
        if (e.count != CNT_MAX) e.count++;
        if (p > e.high_p) e.high_p = p;
        if (p < e.low_p) e.low_p = p;
        e.close_p = p;
      end
      e.win_vol = (v >= e.first_vol) ? v - e.first_vol : '0;
    end
    if (t >= e.win_end) begin
      b = '{s[SLOT_W-1:0], e.win_start, e.win_end, e.open_p, e.high_p, e.low_p,
            e.close_p, e.win_vol, e.count};
      bar_queue = {bar_queue, b};
      // window jumps to the interval that holds the trade
      d = t - e.win_end;
      k = (d == 0) ? 64'd0 : (d - 1) / iv;
      st = e.win_end + k * iv;
      e.win_start = st[TIME_W-1:0];
      d = sat_add(st, iv);
      e.win_end = d[TIME_W-1:0];
      e.count = 1; e.first_vol = v; e.win_vol = '0;
      e.open_p = p; e.high_p = p; e.low_p = p; e.close_p = p;
    end
    book[s] = e;
  endtask

  always @(posedge clk) begin
    bar_t x;
    if (rst) begin
      bar_len <= IV_RESET;
      foreach (armed[i]) armed[i] = 1'b0;
      bar_queue.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (bar_queue.size() == 0) begin
          if (fail_count < 10) $display("unexpected bar for slot %0d", bar_slot);
          fail_count++;
        end else begin
          x = bar_queue.pop_front();
          if (x !== {bar_slot, bar_start, bar_end, open_price, high_price, low_price,
                     close_price, bar_volume, tick_count}) begin
            if (fail_count < 10) begin
              $display("bar mismatch slot exp %0d got %0d start exp %0d got %0d end exp %0d got %0d",
                       x.bslot, bar_slot, x.bstart, bar_start, x.bend, bar_end);
              $display("  o/h/l/c exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                       x.op, x.hp, x.lp, x.cp, open_price, high_price, low_price, close_price);
              $display("  vol exp %0d got %0d cnt exp %0d got %0d",
                       x.vol, bar_volume, x.cnt, tick_count);
            end
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        fold_request(cmd, int'(slot), {1'b0, time_ns}, price, cum_volume);
      if (cfg_valid && cfg_ready) bar_len <= interval_ns;
    end
    bars_pending <= bar_queue.size();
  end
endmodule

/* sim/ohlc_bar_aggregator_test.sv */
// testbench top for the ohlc bar aggregator: clock, reset, requests, bar
// consumer and verdict; depends on ohlc_pkg, ohlc_bar_aggregator, ohlc_bar_checker
`timescale 1ns / 1ps
module ohlc_bar_aggregator_test;
  import ohlc_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IV_W-1:0] interval_ns = IV_RESET;
  logic in_valid = 1'b0;
  logic in_stall;
  logic cmd = CMD_SUBSCRIBE;
  logic [SLOT_W-1:0] slot = '0;
  logic [TIME_W-1:0] time_ns = '0;
  logic signed [PRICE_W-1:0] price = '0;
  logic [VOL_W-1:0] cum_volume = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic [SLOT_W-1:0] bar_slot;
  logic [TIME_W-1:0] bar_start, bar_end;
  logic signed [PRICE_W-1:0] open_price, high_price, low_price, close_price;
  logic [VOL_W-1:0] bar_volume;
  logic [CNT_W-1:0] tick_count;
  int fail_count, bars_pending;

  // gaps off during some stretches so back-to-back requests happen too
  logic no_idle = 1'b0;
  logic armed_slot [SLOTS];
  logic [63:0] last_time [SLOTS];
  logic [VOL_W-1:0] last_vol [SLOTS];
  logic [IV_W-1:0] cur_len = IV_RESET;

  localparam logic signed [PRICE_W-1:0] PRICE_MAX = {1'b0, {(PRICE_W-1){1'b1}}};
  localparam logic signed [PRICE_W-1:0] PRICE_MIN = {1'b1, {(PRICE_W-1){1'b0}}};
  localparam logic [63:0] T_MAX = {1'b0, TIME_MAX};

  always #6 clk = ~clk;

  ohlc_bar_aggregator u_top (.*);

  ohlc_bar_checker u_check (.*);

  // bar consumer: random stall before each bar
  initial begin
    int n;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      n = no_idle ? 0 : $urandom_range(0, 16);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // one request on the input channel, random gap first
  task automatic send_request(input logic c, input int s, input logic [63:0] t,
                              input logic signed [PRICE_W-1:0] p, input logic [VOL_W-1:0] v);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    slot <= s[SLOT_W-1:0];
    time_ns <= t[TIME_W-1:0];
    price <= p;
    cum_volume <= v;
    do @(posedge clk); while (in_stall);
    // mirror of the armed bits so random trades mostly hit live slots
    if (c == CMD_SUBSCRIBE && !armed_slot[s]) begin
      armed_slot[s] = 1'b1;
      last_time[s] = t;
    end
  endtask

  // wait for every bar, let a subscribe finish, then write the interval
  task automatic set_interval(input logic [IV_W-1:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (bars_pending != 0) @(posedge clk);
    repeat (90) @(posedge clk);
    cfg_valid <= 1'b1;
    interval_ns <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_len = v;
  endtask

  function automatic logic [63:0] rand_time();
    return ({$urandom, $urandom} >> 1) >> $urandom_range(0, 40);
  endfunction

  function automatic logic signed [PRICE_W-1:0] rand_price();
    return PRICE_W'({$urandom, $urandom});
  endfunction

  initial begin
    logic [63:0] iv, t, step;
    logic [VOL_W-1:0] v;
    int s, r;
    logic [IV_W-1:0] lens [7];
    foreach (armed_slot[i]) begin
      armed_slot[i] = 1'b0;
      last_time[i] = '0;
      last_vol[i] = '0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: default one-minute interval
    send_request(CMD_TRADE, 1, 64'd5, 48'sd1, 48'd1);               // unarmed slot
    send_request(CMD_SUBSCRIBE, 0, 64'd0, 0, 0);                    // window [60s, 120s]
    send_request(CMD_SUBSCRIBE, 0, 64'd999, 0, 0);                  // already armed
    send_request(CMD_TRADE, 0, 64'd10, 48'sd7, 48'd3);              // before window start
    send_request(CMD_TRADE, 0, 64'd60000000000, PRICE_MAX, 48'd100);
    send_request(CMD_TRADE, 0, 64'd61000000000, PRICE_MIN, 48'd50); // volume below first
    send_request(CMD_TRADE, 0, 64'd70000000000, 48'sd0, '1);
    send_request(CMD_TRADE, 0, 64'd120000000000, -48'sd3, 48'd200); // exactly at end
    send_request(CMD_TRADE, 0, 64'd900000000001, 48'sd9, 48'd300);  // jumps several windows
    send_request(CMD_SUBSCRIBE, 2, 64'd59999999999, 0, 0);
    send_request(CMD_TRADE, 2, 64'd400000000000, 48'sd4, 48'd1);    // empty bar
    send_request(CMD_SUBSCRIBE, 255, T_MAX - 64'd5, 0, 0);          // window saturates
    send_request(CMD_TRADE, 255, T_MAX, PRICE_MAX, '1);
    send_request(CMD_TRADE, 255, T_MAX, PRICE_MIN, '0);
    send_request(CMD_SUBSCRIBE, 3, T_MAX, 0, 0);
    send_request(CMD_TRADE, 3, T_MAX, -48'sd1, 48'd5);

    // hold off until every bar has come back
    in_valid <= 1'b0;
    @(posedge clk);
    while (bars_pending != 0) @(posedge clk);

    lens = '{46'd1, 46'd0, '1, 46'd1000, 46'd37, IV_RESET, 46'd0};
    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 7) set_interval(lens[ph]);
      else set_interval($urandom_range(1, 1 << 20) << $urandom_range(0, 25));
      iv = (cur_len == 0) ? 64'd1 : {18'd0, cur_len};
      no_idle = (ph % 3 == 2);
      for (int n = 0; n < 205; n++) begin
        r = $urandom_range(0, 99);
        s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, SLOTS - 1) : $urandom_range(0, 15);
        if (r < 8 || (!armed_slot[s] && r < 90)) begin
          t = ($urandom_range(0, 9) == 0) ? rand_time() : (last_time[s] | 64'd1) << 1 >> 1;
          if (!armed_slot[s]) t = rand_time();
          send_request(CMD_SUBSCRIBE, s, t, 0, 0);
        end else if (r < 90) begin
          case ($urandom_range(0, 3))
            0: step = iv * $urandom_range(1, 3);
            1: step = iv + $urandom_range(0, 2);
            default: step = {$urandom, $urandom} % (iv / 4 + 1);
          endcase
          t = last_time[s] + step;
          if (t > T_MAX || t < last_time[s]) t = T_MAX;
          last_time[s] = t;
          v = ($urandom_range(0, 9) == 0) ? VOL_W'({$urandom, $urandom}) :
              last_vol[s] + VOL_W'($urandom_range(0, 5000));
          last_vol[s] = v;
          send_request(CMD_TRADE, s, t, rand_price(), v);
        end else begin
          // noise: random slot, random time, may be unarmed or before the window
          send_request(CMD_TRADE, $urandom_range(0, SLOTS - 1), {$urandom, $urandom},
                       rand_price(), VOL_W'({$urandom, $urandom}));
        end
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (bars_pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && bars_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("status: fail");
    $finish;
  end
endmodule
